[hdl/tvcf_pkg.sv]
// ----------------------------------------------------------------------------
// Time-varying channel FIR package
// Shared widths, command codes, controller states and control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tvcf_pkg;

  localparam int CMD_W     = 2;
  localparam int TAP_IDX_W = 4;
  localparam int GAIN_W    = 18;
  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 24;
  localparam int CFG_W     = 5;
  localparam int PROD_W    = GAIN_W + SAMPLE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_GAIN = 2'd0,
    CMD_PUSH       = 2'd1,
    CMD_CLEAR      = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic gain_we;
    logic hist_push;
    logic hist_clr;
    logic rotate;
    logic mac_en;
    logic acc_clr;
    logic round_en;
    logic out_load;
  } ctrl_t;

endpackage

`default_nettype wire

[hdl/tvcf_in_if.sv]
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvcf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [tvcf_pkg::CMD_W-1:0]             command;
  logic [tvcf_pkg::TAP_IDX_W-1:0]         tap_index;
  logic signed [tvcf_pkg::GAIN_W-1:0]     gain_real;
  logic signed [tvcf_pkg::GAIN_W-1:0]     gain_imag;
  logic signed [tvcf_pkg::SAMPLE_W-1:0]   sample_real;
  logic signed [tvcf_pkg::SAMPLE_W-1:0]   sample_imag;

  modport source (output valid, command, tap_index, gain_real, gain_imag,
                  sample_real, sample_imag, input ready);
  modport sink (input valid, command, tap_index, gain_real, gain_imag,
                sample_real, sample_imag, output ready);
endinterface

`default_nettype wire

[hdl/tvcf_out_if.sv]
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one filtered sample transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvcf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tvcf_pkg::OUT_W-1:0]   out_real;
  logic signed [tvcf_pkg::OUT_W-1:0]   out_imag;
  logic                                saturated;

  modport source (output valid, out_real, out_imag, saturated, input ready);
  modport sink (input valid, out_real, out_imag, saturated, output ready);
endinterface

`default_nettype wire

[hdl/tvcf_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the active tap count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvcf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tvcf_pkg::CFG_W-1:0] active_taps;

  modport source (output valid, active_taps, input ready);
  modport sink (input valid, active_taps, output ready);
endinterface

`default_nettype wire

[hdl/tvcf_ctrl.sv]
// ----------------------------------------------------------------------------
// Time-varying channel FIR controller
// Accepts transactions, holds the tap count, sequences one MAC per active tap.
// ----------------------------------------------------------------------------
`default_nettype none

module tvcf_ctrl #(
  parameter int TAPS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [tvcf_pkg::CMD_W-1:0]     in_command_i,
  input  wire logic [tvcf_pkg::TAP_IDX_W-1:0] tap_index_i,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [tvcf_pkg::CFG_W-1:0]     cfg_taps_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      tvcf_pkg::ctrl_t                ctrl_o
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int N_W   = $clog2(TAPS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(TAPS - 1);
  localparam logic [N_W-1:0]   TAPS_RESET = N_W'((TAPS < 16) ? TAPS : 16);

  tvcf_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N_W-1:0]   taps_q, taps_d;
  logic             out_vld_q, out_vld_d;
  logic             accept;
  logic [7:0]       cfg_ext;
  logic [N_W+3:0]   idx_ext;
  logic [N_W+3:0]   taps_ext;

  assign in_ready_o  = (state_q == tvcf_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign accept      = in_valid_i && in_ready_o;
  assign idx_ext     = {{N_W{1'b0}}, tap_index_i};
  assign taps_ext    = {4'b0, taps_q};
  assign cfg_ext     = {3'b0, cfg_taps_i};

  // clamp tap count to 1..TAPS
  always_comb begin
    taps_d = taps_q;
    if (cfg_valid_i) begin
      if (cfg_ext == 8'd0) begin
        taps_d = N_W'(1);
      end else if (cfg_ext > 8'(TAPS)) begin
        taps_d = N_W'(TAPS);
      end else begin
        taps_d = N_W'(cfg_ext);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tvcf_pkg::ST_IDLE: begin
        if (accept && in_command_i == tvcf_pkg::CMD_PUSH) begin
          state_d = tvcf_pkg::ST_RUN;
        end
      end
      tvcf_pkg::ST_RUN: begin
        if (cnt_q == CNT_LAST) begin
          state_d = tvcf_pkg::ST_DRAIN;
        end
      end
      tvcf_pkg::ST_DRAIN: state_d = tvcf_pkg::ST_ROUND;
      tvcf_pkg::ST_ROUND: state_d = tvcf_pkg::ST_DONE;
      tvcf_pkg::ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          state_d = tvcf_pkg::ST_IDLE;
        end
      end
      default: state_d = tvcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    cnt_d  = cnt_q;
    case (state_q)
      tvcf_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_command_i)
            tvcf_pkg::CMD_WRITE_GAIN: ctrl_o.gain_we = (idx_ext < taps_ext);
            tvcf_pkg::CMD_PUSH: begin
              ctrl_o.hist_push = 1'b1;
              ctrl_o.acc_clr   = 1'b1;
              cnt_d            = '0;
            end
            tvcf_pkg::CMD_CLEAR: ctrl_o.hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      tvcf_pkg::ST_RUN: begin
        ctrl_o.rotate = 1'b1;
        ctrl_o.mac_en = (N_W'(cnt_q) < taps_q);
        cnt_d         = cnt_q + CNT_W'(1);
      end
      tvcf_pkg::ST_ROUND: ctrl_o.round_en = 1'b1;
      tvcf_pkg::ST_DONE: ctrl_o.out_load = !out_vld_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (ctrl_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tvcf_pkg::ST_IDLE;
      cnt_q     <= '0;
      taps_q    <= TAPS_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      taps_q    <= taps_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tvcf_pkg::ST_DONE && out_vld_q && !out_ready_i)
      |=> (state_q == tvcf_pkg::ST_DONE))
    else $error("pending result overwritten");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> out_vld_q)
    else $error("result load lost");

  a_push_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.hist_push |=> (state_q == tvcf_pkg::ST_RUN && cnt_q == '0))
    else $error("push did not start tap sweep");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tvcf_pkg::ST_RUN && cnt_q == CNT_LAST)
      |=> (state_q == tvcf_pkg::ST_DRAIN))
    else $error("tap sweep overran");

endmodule

`default_nettype wire

[hdl/tvcf_dp.sv]
// ----------------------------------------------------------------------------
// Time-varying channel FIR datapath
// Rotating history and gain lines, complex MAC, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tvcf_dp #(
  parameter int TAPS           = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire tvcf_pkg::ctrl_t                       ctrl_i,
  input  wire logic [tvcf_pkg::TAP_IDX_W-1:0]        tap_index_i,
  input  wire logic signed [tvcf_pkg::GAIN_W-1:0]    gain_real_i,
  input  wire logic signed [tvcf_pkg::GAIN_W-1:0]    gain_imag_i,
  input  wire logic signed [tvcf_pkg::SAMPLE_W-1:0]  sample_real_i,
  input  wire logic signed [tvcf_pkg::SAMPLE_W-1:0]  sample_imag_i,
  output      logic signed [tvcf_pkg::OUT_W-1:0]     out_real_o,
  output      logic signed [tvcf_pkg::OUT_W-1:0]     out_imag_o,
  output      logic                                  saturated_o
);

  localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W = tvcf_pkg::PROD_W;
  localparam int ACC_W  = PROD_W + 2 + $clog2(TAPS);
  localparam int RND_W  = ACC_W + 1;
  localparam int OUT_W  = tvcf_pkg::OUT_W;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (GAIN_FRAC_BITS - 1);

  logic signed [tvcf_pkg::SAMPLE_W-1:0] hist_re_q [TAPS];
  logic signed [tvcf_pkg::SAMPLE_W-1:0] hist_im_q [TAPS];
  logic signed [tvcf_pkg::GAIN_W-1:0]   gain_re_q [TAPS];
  logic signed [tvcf_pkg::GAIN_W-1:0]   gain_im_q [TAPS];

  logic [IDX_W+3:0]          idx_ext;
  logic [IDX_W-1:0]          wr_idx;
  logic signed [PROD_W-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic                      p_vld_q;
  logic signed [PROD_W:0]    term_re, term_im;
  logic signed [ACC_W-1:0]   acc_re_q, acc_im_q;
  logic signed [RND_W-1:0]   rnd_re_d, rnd_im_d, rnd_re_q, rnd_im_q;
  logic                      fit_re, fit_im;
  logic signed [OUT_W-1:0]   sat_re, sat_im;
  logic signed [OUT_W-1:0]   out_re_q, out_im_q;
  logic                      sat_q;

  assign idx_ext = {{IDX_W{1'b0}}, tap_index_i};
  assign wr_idx  = idx_ext[IDX_W-1:0];

  // history: push, clear, rotate toward index zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_re_q[i] <= '0;
        hist_im_q[i] <= '0;
      end
    end else if (ctrl_i.hist_clr) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_re_q[i] <= '0;
        hist_im_q[i] <= '0;
      end
    end else if (ctrl_i.hist_push) begin
      hist_re_q[0] <= sample_real_i;
      hist_im_q[0] <= sample_imag_i;
      for (int i = 1; i < TAPS; i++) begin
        hist_re_q[i] <= hist_re_q[i-1];
        hist_im_q[i] <= hist_im_q[i-1];
      end
    end else if (ctrl_i.rotate) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        hist_re_q[i] <= hist_re_q[i+1];
        hist_im_q[i] <= hist_im_q[i+1];
      end
      hist_re_q[TAPS-1] <= hist_re_q[0];
      hist_im_q[TAPS-1] <= hist_im_q[0];
    end
  end

  // gains: write one tap, rotate in step with history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        gain_re_q[i] <= '0;
        gain_im_q[i] <= '0;
      end
    end else if (ctrl_i.gain_we) begin
      gain_re_q[wr_idx] <= gain_real_i;
      gain_im_q[wr_idx] <= gain_imag_i;
    end else if (ctrl_i.rotate) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        gain_re_q[i] <= gain_re_q[i+1];
        gain_im_q[i] <= gain_im_q[i+1];
      end
      gain_re_q[TAPS-1] <= gain_re_q[0];
      gain_im_q[TAPS-1] <= gain_im_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    p_rr_q <= PROD_W'(gain_re_q[0] * hist_re_q[0]);
    p_ii_q <= PROD_W'(gain_im_q[0] * hist_im_q[0]);
    p_ri_q <= PROD_W'(gain_re_q[0] * hist_im_q[0]);
    p_ir_q <= PROD_W'(gain_im_q[0] * hist_re_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= ctrl_i.mac_en;
    end
  end

  assign term_re = (PROD_W+1)'(p_rr_q) - (PROD_W+1)'(p_ii_q);
  assign term_im = (PROD_W+1)'(p_ri_q) + (PROD_W+1)'(p_ir_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (p_vld_q) begin
      acc_re_q <= acc_re_q + ACC_W'(term_re);
      acc_im_q <= acc_im_q + ACC_W'(term_im);
    end
  end

  // round half up, then arithmetic shift
  assign rnd_re_d = (RND_W'(acc_re_q) + HALF) >>> GAIN_FRAC_BITS;
  assign rnd_im_d = (RND_W'(acc_im_q) + HALF) >>> GAIN_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.round_en) begin
      rnd_re_q <= rnd_re_d;
      rnd_im_q <= rnd_im_d;
    end
  end

  assign fit_re = (&rnd_re_q[RND_W-1:OUT_W-1]) || !(|rnd_re_q[RND_W-1:OUT_W-1]);
  assign fit_im = (&rnd_im_q[RND_W-1:OUT_W-1]) || !(|rnd_im_q[RND_W-1:OUT_W-1]);

  always_comb begin
    sat_re = rnd_re_q[OUT_W-1:0];
    sat_im = rnd_im_q[OUT_W-1:0];
    if (!fit_re) begin
      sat_re = rnd_re_q[RND_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
    if (!fit_im) begin
      sat_im = rnd_im_q[RND_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_re_q <= sat_re;
      out_im_q <= sat_im;
      sat_q    <= !fit_re || !fit_im;
    end
  end

  assign out_real_o  = out_re_q;
  assign out_imag_o  = out_im_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

[hdl/time_varying_channel_fir_top.sv]
// Sequence: an accepted push runs one complex MAC per active tap over a
// rotating delay line, then passes ST_DRAIN and ST_ROUND to ST_DONE, where the
// result is loaded once the output is free; commands are taken only in ST_IDLE.
// Reset: history and tap gains clear to zero, active tap count to TAPS (max 16).
// Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
// Time-varying channel FIR top level
// Tapped delay line with rewritable complex gains and saturated output.
// ----------------------------------------------------------------------------
`default_nettype none

module time_varying_channel_fir_top #(
  parameter int TAPS           = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  tvcf_in_if.sink   in_if,
  tvcf_out_if.source out_if,
  tvcf_cfg_if.sink  cfg_if
);

  tvcf_pkg::ctrl_t ctrl;

  tvcf_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .in_command_i (in_if.command),
    .tap_index_i  (in_if.tap_index),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_o  (cfg_if.ready),
    .cfg_taps_i   (cfg_if.active_taps),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .ctrl_o       (ctrl)
  );

  tvcf_dp #(
    .TAPS           (TAPS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .tap_index_i   (in_if.tap_index),
    .gain_real_i   (in_if.gain_real),
    .gain_imag_i   (in_if.gain_imag),
    .sample_real_i (in_if.sample_real),
    .sample_imag_i (in_if.sample_imag),
    .out_real_o    (out_if.out_real),
    .out_imag_o    (out_if.out_imag),
    .saturated_o   (out_if.saturated)
  );

endmodule

`default_nettype wire

[tb/time_varying_channel_fir_top_tb.sv]
// ----------------------------------------------------------------------------
// Time-varying channel FIR testbench
// Drives gain writes, sample pushes, history clears and unused commands through
// the input channel under random idling and stalls, rewrites the tap count
// between phases, and checks every filtered sample against a scoreboard that
// keeps its own copy of the delay line, the tap gains and the tap count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_varying_channel_fir_top_tb;

  import tvcf_pkg::*;

  localparam int TAPS           = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int LATENCY        = TAPS + 4;
  localparam int SETTLE_CYCLES  = LATENCY + 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 65;
  localparam int CYCLE_LIMIT    = 200000;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = 18'sh1FFFF;
  localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = 18'sh20000;
  localparam logic signed [GAIN_W-1:0]   GAIN_ONE   = 18'sd4096;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    sat;
  } filtered_t;

  class channel_scoreboard;
    localparam int  DEPTH   = 16;
    localparam int  FRAC    = 12;
    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;

    logic signed [SAMPLE_W-1:0] hist_re [DEPTH];
    logic signed [SAMPLE_W-1:0] hist_im [DEPTH];
    logic signed [GAIN_W-1:0]   gain_re [DEPTH];
    logic signed [GAIN_W-1:0]   gain_im [DEPTH];
    int unsigned                span;
    filtered_t                  filtered_q [$];
    int mismatches, n_results, n_clipped, n_writes, n_clears, n_settings;

    function new();
      for (int l = 0; l < DEPTH; l++) begin
        hist_re[l] = '0;
        hist_im[l] = '0;
        gain_re[l] = '0;
        gain_im[l] = '0;
      end
      span       = DEPTH;
      mismatches = 0;
      n_results  = 0;
      n_clipped  = 0;
      n_writes   = 0;
      n_clears   = 0;
      n_settings = 0;
    endfunction

    function void set_taps(logic [CFG_W-1:0] value);
      span = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : value);
      n_settings++;
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction

    function filtered_t filter_sample(logic signed [SAMPLE_W-1:0] sr,
                                      logic signed [SAMPLE_W-1:0] si);
      filtered_t res;
      longint acc_re, acc_im, gr, gi, xr, xi, yr, yi;
      for (int l = DEPTH - 1; l > 0; l--) begin
        hist_re[l] = hist_re[l-1];
        hist_im[l] = hist_im[l-1];
      end
      hist_re[0] = sr;
      hist_im[0] = si;
      acc_re = 0;
      acc_im = 0;
      for (int l = 0; l < span; l++) begin
        gr = gain_re[l];
        gi = gain_im[l];
        xr = hist_re[l];
        xi = hist_im[l];
        acc_re += gr * xr - gi * xi;
        acc_im += gr * xi + gi * xr;
      end
      // round half up, then floor shift
      yr = (acc_re + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      yi = (acc_im + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      res.sat = 1'b0;
      if (yr > OUT_MAX) begin
        yr = OUT_MAX;
        res.sat = 1'b1;
      end else if (yr < OUT_MIN) begin
        yr = OUT_MIN;
        res.sat = 1'b1;
      end
      if (yi > OUT_MAX) begin
        yi = OUT_MAX;
        res.sat = 1'b1;
      end else if (yi < OUT_MIN) begin
        yi = OUT_MIN;
        res.sat = 1'b1;
      end
      res.re = yr[OUT_W-1:0];
      res.im = yi[OUT_W-1:0];
      if (res.sat) n_clipped++;
      return res;
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [TAP_IDX_W-1:0] idx,
                             logic signed [GAIN_W-1:0] gr, logic signed [GAIN_W-1:0] gi,
                             logic signed [SAMPLE_W-1:0] sr,
                             logic signed [SAMPLE_W-1:0] si);
      case (cmd)
        CMD_WRITE_GAIN: begin
          if (idx < span) begin
            gain_re[idx] = gr;
            gain_im[idx] = gi;
            n_writes++;
          end
        end
        CMD_PUSH: filtered_q.push_back(filter_sample(sr, si));
        CMD_CLEAR: begin
          for (int l = 0; l < DEPTH; l++) begin
            hist_re[l] = '0;
            hist_im[l] = '0;
          end
          n_clears++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [OUT_W-1:0] re, logic signed [OUT_W-1:0] im,
                               logic sat);
      filtered_t want;
      if (filtered_q.size() == 0) begin
        $error("unexpected filtered sample: out_real=%0d out_imag=%0d saturated=%0b",
               re, im, sat);
        mismatches++;
        return;
      end
      want = filtered_q.pop_front();
      n_results++;
      if (re !== want.re) begin
        $error("out_real: expected %0d, actual %0d", want.re, re);
        mismatches++;
      end
      if (im !== want.im) begin
        $error("out_imag: expected %0d, actual %0d", want.im, im);
        mismatches++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %0b, actual %0b", want.sat, sat);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tvcf_in_if  in_ch ();
  tvcf_out_if out_ch ();
  tvcf_cfg_if cfg_ch ();

  channel_scoreboard sb;
  int  cycle_count = 0;
  int  sent_items  = 0;
  int  taps_now    = TAPS;
  bit  src_steady  = 1'b0;
  bit  snk_steady  = 1'b0;
  bit  sink_hold_req = 1'b0;

  time_varying_channel_fir_top #(
    .TAPS          (TAPS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("time_varying_channel_fir_top test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.out_real, out_ch.out_imag, out_ch.saturated);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.command, in_ch.tap_index, in_ch.gain_real, in_ch.gain_imag,
                      in_ch.sample_real, in_ch.sample_imag);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.set_taps(cfg_ch.active_taps);
      end
    end
  end

  function automatic int draw_wait(bit steady);
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    int v;
    case ($urandom_range(0, 7))
      0: return GAIN_MAX;
      1: return GAIN_MIN;
      2, 3: return GAIN_W'($urandom);
      default: begin
        v = $urandom_range(0, 16383) - 8192;
        return GAIN_W'(v);
      end
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // sink: random stalls, plus one long hold on request
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end else begin
        hold = draw_wait(snk_steady);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TAP_IDX_W-1:0] idx,
                          input logic signed [GAIN_W-1:0] gr,
                          input logic signed [GAIN_W-1:0] gi,
                          input logic signed [SAMPLE_W-1:0] sr,
                          input logic signed [SAMPLE_W-1:0] si);
    int gap;
    gap = draw_wait(src_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.tap_index   <= idx;
    in_ch.gain_real   <= gr;
    in_ch.gain_imag   <= gi;
    in_ch.sample_real <= sr;
    in_ch.sample_imag <= si;
    do @(posedge clk_i); while (!in_ch.ready);
    if (!(cmd == CMD_UNUSED || (cmd == CMD_WRITE_GAIN && idx >= taps_now))) begin
      sent_items++;
    end
  endtask

  task automatic send_noise();
    send_cmd(CMD_W'($urandom), TAP_IDX_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
             SAMPLE_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic apply_taps(input logic [CFG_W-1:0] value);
    drain_results();
    // gain writes and clears leave no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.active_taps <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    taps_now = (value == 0) ? 1 : ((value > TAPS) ? TAPS : value);
  endtask

  // frame: optional clear, a few gain writes, then a burst of samples
  task automatic run_frame();
    int n_gain, n_push;
    logic [TAP_IDX_W-1:0] idx;
    if ($urandom_range(0, 1) == 1) begin
      send_cmd(CMD_CLEAR, TAP_IDX_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
               SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    end
    n_gain = $urandom_range(0, taps_now);
    repeat (n_gain) begin
      if ($urandom_range(0, 7) == 0) idx = TAP_IDX_W'($urandom);
      else idx = TAP_IDX_W'($urandom_range(0, taps_now - 1));
      send_cmd(CMD_WRITE_GAIN, idx, pick_gain(), pick_gain(), SAMPLE_W'($urandom),
               SAMPLE_W'($urandom));
    end
    n_push = $urandom_range(1, 6);
    repeat (n_push) begin
      send_cmd(CMD_PUSH, TAP_IDX_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
               pick_sample(), pick_sample());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] tap_settings [8];
    int phase_end;
    bit paused;
    sb = new();
    in_ch.valid        <= 1'b0;
    in_ch.command      <= '0;
    in_ch.tap_index    <= '0;
    in_ch.gain_real    <= '0;
    in_ch.gain_imag    <= '0;
    in_ch.sample_real  <= '0;
    in_ch.sample_imag  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.active_taps <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gains, identity tap, edge tap, unused command, clear,
    // clipping both ways, rounding tie
    send_cmd(CMD_PUSH, 4'd0, 18'sd0, 18'sd0, 16'sd1, -16'sd1);
    send_cmd(CMD_WRITE_GAIN, 4'd0, GAIN_ONE, 18'sd0, 16'sd0, 16'sd0);
    send_cmd(CMD_PUSH, 4'd0, 18'sd0, 18'sd0, SAMPLE_MAX, SAMPLE_MIN);
    send_cmd(CMD_WRITE_GAIN, 4'd15, GAIN_MIN, GAIN_MAX, 16'sd0, 16'sd0);
    send_cmd(CMD_UNUSED, 4'd15, GAIN_MAX, GAIN_MIN, SAMPLE_MAX, SAMPLE_MIN);
    send_cmd(CMD_CLEAR, 4'd0, 18'sd0, 18'sd0, 16'sd0, 16'sd0);
    send_cmd(CMD_PUSH, 4'd0, 18'sd0, 18'sd0, -16'sd1, 16'sd1);
    for (int t = 0; t < 5; t++) begin
      send_cmd(CMD_WRITE_GAIN, TAP_IDX_W'(t), GAIN_MIN, GAIN_MAX, 16'sd0, 16'sd0);
    end
    repeat (5) send_cmd(CMD_PUSH, 4'd0, 18'sd0, 18'sd0, SAMPLE_MIN, SAMPLE_MIN);
    repeat (5) send_cmd(CMD_PUSH, 4'd0, 18'sd0, 18'sd0, SAMPLE_MAX, SAMPLE_MAX);
    send_cmd(CMD_CLEAR, 4'd0, 18'sd0, 18'sd0, 16'sd0, 16'sd0);
    send_cmd(CMD_WRITE_GAIN, 4'd0, 18'sd1, 18'sd0, 16'sd0, 16'sd0);
    send_cmd(CMD_PUSH, 4'd0, 18'sd0, 18'sd0, 16'sd2048, -16'sd2048);

    tap_settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd0, 5'd16};
    tap_settings[6] = CFG_W'($urandom_range(2, 15));
    for (int p = 0; p < 8; p++) begin
      apply_taps(tap_settings[p]);
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      if (p == 7) begin
        src_steady    = 1'b1;
        sink_hold_req = 1'b1;
      end
      paused    = 1'b0;
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        if (p == 2 && !paused && sent_items >= phase_end - PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) run_frame();
        else send_noise();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d filtered samples (%0d clipped) after %0d gain writes and %0d clears",
             sb.n_results, sb.n_clipped, sb.n_writes, sb.n_clears);
    $display("over %0d tap-count settings, including the clamped values 0, 17 and 31",
             sb.n_settings);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("time_varying_channel_fir_top test passed");
    end else begin
      $display("time_varying_channel_fir_top test failed");
    end
    $finish;
  end

endmodule
